// File: design/ebj_pkg.sv
package ebj_pkg;

    localparam int MS_W     = 19;
    localparam int ROUNDS_W = 7;
    localparam int GEN_W    = 64;
    localparam int REM_W    = MS_W + 1;
    localparam int CFG_W    = 2;

    localparam logic [GEN_W-1:0] GOLDEN_SEED = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [MS_W-1:0]  INITIAL_RST = 19'd100;
    localparam logic [MS_W-1:0]  MAXIMUM_RST = 19'd300000;

    typedef enum logic [CFG_W-1:0] {
        CFG_INITIAL = 2'd0,
        CFG_MAXIMUM = 2'd1,
        CFG_SEED    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAP,
        ST_MOD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

endpackage

// File: design/ebj_mod.sv
module ebj_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ebj_pkg::GEN_W-1:0]   i_dividend,
    input  logic [ebj_pkg::REM_W-1:0]   i_divisor,
    output ebj_pkg::t_mod_stat          o_stat,
    output logic [ebj_pkg::REM_W-1:0]   o_rem
);
    import ebj_pkg::*;

    localparam int CNT_W = $clog2(GEN_W + 1);

    logic [GEN_W-1:0] r_num;
    logic [REM_W-1:0] r_div;
    logic [REM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REM_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_num[GEN_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(GEN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[GEN_W-2:0], 1'b0};
            if (fits) begin
                r_rem <= REM_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[REM_W-1:0];
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

// File: design/exponential_backoff_jitter.sv
// Exponential backoff with full jitter.
// Input channel: i_valid / o_stall carry i_failed_rounds. A request is taken
// when i_valid is high and o_stall is low; o_stall is high from the cycle
// after acceptance until the result has been moved into the output register.
// Output channel: o_valid / i_stall carry o_delay_ms and o_cap_ms; the output
// register holds its result while i_stall is high, and a new request may be
// taken while that result waits.
// Config channel: i_cfg_valid / o_cfg_ready (always ready) with i_cfg_index
// 0 = initial backoff, 1 = maximum backoff, 2 = seed (reloads the generator).
// Sequence: after acceptance the cap is doubled D times, where D is the
// number of cap doublings (0 to MAX_ROUNDS-1, one per cycle, ending early
// once the cap reaches the maximum). The cap loop then closes and starts the
// bit-serial restoring modulo (one dividend bit per cycle plus its done
// flag), and the result is then loaded into the output register. A new
// request is not taken until that result has moved to the output register.
// Reset: initial backoff 100, maximum 300000, seed 0 (the generator loads
// the golden-ratio constant). A stalled receiver holds the finished result
// in the block until the output register frees up.
module exponential_backoff_jitter #(
    parameter int MAX_ROUNDS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ebj_pkg::ROUNDS_W-1:0]   i_failed_rounds,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ebj_pkg::MS_W-1:0]       o_delay_ms,
    output logic [ebj_pkg::MS_W-1:0]       o_cap_ms,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ebj_pkg::CFG_W-1:0]      i_cfg_index,
    input  logic [ebj_pkg::GEN_W-1:0]      i_cfg_data
);
    import ebj_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [MS_W-1:0]    r_initial;
    logic [MS_W-1:0]    r_maximum;
    logic [GEN_W-1:0]   r_gen;
    logic [MS_W-1:0]    r_cap;
    logic [ROUNDS_W-1:0] r_cnt;
    logic               r_out_valid;
    logic [MS_W-1:0]    r_out_delay;
    logic [MS_W-1:0]    r_out_cap;

    logic               accept;
    logic               mod_start;
    logic               load_out;
    logic               out_free;
    logic [GEN_W-1:0]   gen_a;
    logic [GEN_W-1:0]   gen_b;
    logic [GEN_W-1:0]   gen_next;
    logic [ROUNDS_W-1:0] limit;
    logic [MS_W:0]      doubled;
    logic [REM_W-1:0]   mod_rem;
    t_mod_stat          mod_stat;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign gen_a    = r_gen ^ (r_gen << 13);
    assign gen_b    = gen_a ^ (gen_a >> 7);
    assign gen_next = gen_b ^ (gen_b << 17);

    assign limit   = (int'(i_failed_rounds) > MAX_ROUNDS) ? ROUNDS_W'(MAX_ROUNDS)
                                                          : i_failed_rounds;
    assign doubled = {r_cap, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_stall   = 1'b1;
        mod_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = ST_CAP;
                end
            end
            ST_CAP: begin
                if (r_cnt == '0 || r_cap >= r_maximum) begin
                    mod_start = 1'b1;
                    n_state   = ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial   <= INITIAL_RST;
            r_maximum   <= MAXIMUM_RST;
            r_gen       <= GOLDEN_SEED;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INITIAL: r_initial <= i_cfg_data[MS_W-1:0];
                    CFG_MAXIMUM: r_maximum <= i_cfg_data[MS_W-1:0];
                    CFG_SEED:    r_gen <= (i_cfg_data == '0) ? GOLDEN_SEED : i_cfg_data;
                    default: ;
                endcase
            end else if (accept) begin
                r_gen <= gen_next;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // load the cap on acceptance, advance it one doubling per cycle, and fill the output register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cap <= r_initial;
            r_cnt <= (limit == '0) ? '0 : limit - 1'b1;
        end else if (r_state == ST_CAP && r_cnt != '0 && r_cap < r_maximum) begin
            r_cnt <= r_cnt - 1'b1;
            if (doubled < {1'b0, r_maximum}) begin
                r_cap <= doubled[MS_W-1:0];
            end else begin
                r_cap <= r_maximum;
            end
        end
        if (load_out) begin
            r_out_delay <= mod_rem[MS_W-1:0];
            r_out_cap   <= r_cap;
        end
    end

    ebj_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_gen),
        .i_divisor  ({1'b0, r_cap} + REM_W'(1)),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    assign o_valid     = r_out_valid;
    assign o_delay_ms  = r_out_delay;
    assign o_cap_ms    = r_out_cap;
    assign o_cfg_ready = 1'b1;

`ifndef ASSERT_OFF
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != '0)
        else $error("generator state reached zero");

    a_delay_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_delay_ms <= o_cap_ms)
        else $error("delay exceeds cap");

    a_accept_to_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_CAP)
        else $error("accepted request did not start the cap loop");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_stat.done |-> r_state == ST_MOD && !mod_stat.busy)
        else $error("modulo finished outside its state");
`endif

endmodule
